FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_CLK: property checked at every rising clock edge outside reset.
// ASSERT_NEVER: expression must never be true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/core/rc5_ird_pkg.sv
package rc5_ird_pkg;

    // Burst and frame limits
    localparam int unsigned MAX_PULSES_N = 100;
    localparam logic [6:0]  MAX_PULSES   = 7'(MAX_PULSES_N);
    localparam logic [3:0]  FRAME_BITS   = 4'd14;
    localparam logic [6:0]  GATE_PULSE   = 7'd10;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIT_PERIOD     = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE      = 2'd1;
    localparam logic [1:0] CFG_WANTED_ADDRESS = 2'd2;
    localparam logic [1:0] CFG_GATE_THRESHOLD = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_BIT_PERIOD     = 16'd900;
    localparam logic [14:0] RST_TOLERANCE      = 15'd150;
    localparam logic [4:0]  RST_WANTED_ADDRESS = 5'd13;
    localparam logic [15:0] RST_GATE_THRESHOLD = 16'd500;

    // Input kinds carried on tuser
    localparam logic FUNC_PULSE   = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    // Exit codes
    localparam logic [1:0] EXIT_FIRST  = 2'd0;
    localparam logic [1:0] EXIT_SECOND = 2'd1;
    localparam logic [1:0] EXIT_OTHER  = 2'd2;

    // Command values with a meaning for direction and exit
    localparam logic [5:0] CMD_R1 = 6'd1;
    localparam logic [5:0] CMD_R2 = 6'd2;
    localparam logic [5:0] CMD_R3 = 6'd3;
    localparam logic [5:0] CMD_L1 = 6'd4;
    localparam logic [5:0] CMD_L2 = 6'd5;

    function automatic logic cmd_direction(input logic [5:0] cmd);
        return (cmd == CMD_R1) || (cmd == CMD_R2) || (cmd == CMD_R3);
    endfunction

    function automatic logic [1:0] cmd_exit(input logic [5:0] cmd);
        logic [1:0] code;
        if ((cmd == CMD_R1) || (cmd == CMD_L1)) begin
            code = EXIT_FIRST;
        end else if ((cmd == CMD_R2) || (cmd == CMD_L2)) begin
            code = EXIT_SECOND;
        end else begin
            code = EXIT_OTHER;
        end
        return code;
    endfunction

endpackage

FILE: rtl/core/rc5_ir_frame_decoder_top.sv
// RC5 infrared frame decoder. Each input transaction is either a measured
// pulse (tuser = 0: edge kind in tdata[0], duration in ticks in tdata[16:1])
// or a burst timeout (tuser = 1). Pulses produce no output; each timeout
// produces exactly one output transaction carrying the sticky available flag,
// the command of the last accepted frame and its decoded direction and exit.
// One transaction is accepted every cycle while no timeout is held back. A
// timeout passes through the input register and then loads the result
// register, which offers it. The input side keeps accepting pulses while a
// result waits. A timeout holds in the input register only while the
// result register is still full. The four
// configuration registers may be written only while no transaction is in
// flight; they take effect on the next transaction.
`include "assert_macros.svh"

module rc5_ir_frame_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [0] rising, [16:1] duration, rest zero
    input  logic        i_s_axis_tuser,   // [0] func
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [0] available, [6:1] command,
                                          // [7] direction_right, [9:8] exit_code
);
    import rc5_ird_pkg::*;

    typedef enum logic [2:0] {
        C_BIT0,
        C_BIT1,
        C_HALF,
        C_INVALID,
        C_RESTART
    } t_code;

    // configuration
    logic [15:0] r_bit_period;
    logic [14:0] r_tolerance;
    logic [4:0]  r_wanted_addr;
    logic [15:0] r_gate_thr;

    // input register
    logic        r_in_vld;
    logic        r_in_func;
    logic        r_in_rising;
    logic [15:0] r_in_dur;

    // burst state
    logic [13:0] r_frame,     n_frame;
    logic [3:0]  r_bit_count, n_bit_count;
    logic        r_last_bit,  n_last_bit;
    logic        r_done,      n_done;
    logic [6:0]  r_pulse_cnt, n_pulse_cnt;
    logic        r_gate_ok,   n_gate_ok;
    logic        r_pend_vld,  n_pend_vld;
    logic [5:0]  r_pend_cmd,  n_pend_cmd;
    logic        r_avail,     n_avail;
    logic [5:0]  r_held_cmd,  n_held_cmd;

    // result register
    logic        r_out_vld;
    logic [15:0] r_out_data,  n_out_data;

    logic        w_out_free;
    logic        w_fire;

    // window limits
    logic [15:0] w_lo1;
    logic [16:0] w_hi1;
    logic [16:0] w_two_t;
    logic [16:0] w_lo2;
    logic [17:0] w_hi2;
    logic        w_one;
    logic        w_two;
    logic        w_one_zero;
    t_code       w_code;

    // timeout fill of the remaining slots
    logic [7:0]  w_fill_end;
    logic        w_fill;
    logic [27:0] w_fill_shift;
    logic [13:0] w_fill_frame;

    // pulse decode scratch
    logic [13:0] w_frame;
    logic [3:0]  w_count;
    logic        w_last;
    logic        w_done;

    // handshake
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_fire          = r_in_vld && ((r_in_func == FUNC_PULSE) || w_out_free);
    assign o_s_axis_tready = !r_in_vld || w_fire;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // classify the duration as one or two half periods
    always_comb begin
        w_lo1      = (r_bit_period > {1'b0, r_tolerance}) ?
                     r_bit_period - {1'b0, r_tolerance} : 16'd0;
        w_hi1      = {1'b0, r_bit_period} + {2'b0, r_tolerance};
        w_two_t    = {r_bit_period, 1'b0};
        w_lo2      = (w_two_t > {2'b0, r_tolerance}) ?
                     w_two_t - {2'b0, r_tolerance} : 17'd0;
        w_hi2      = {1'b0, w_two_t} + {3'b0, r_tolerance};
        w_one      = (r_in_dur >= w_lo1) && ({1'b0, r_in_dur} <= w_hi1);
        w_two      = ({1'b0, r_in_dur} >= w_lo2) && ({2'b0, r_in_dur} <= w_hi2);
        // a zero-length filler pulse falls in the one-period window
        w_one_zero = (r_bit_period <= {1'b0, r_tolerance});
    end

    // map class, edge and last bit to a Manchester code
    always_comb begin
        if (r_in_rising) begin
            if (r_last_bit) begin
                w_code = w_one ? C_HALF : (w_two ? C_BIT0 : C_RESTART);
            end else begin
                w_code = w_one ? C_BIT0 : (w_two ? C_INVALID : C_RESTART);
            end
        end else begin
            if (r_last_bit) begin
                w_code = w_one ? C_BIT1 : (w_two ? C_INVALID : C_RESTART);
            end else begin
                w_code = w_one ? C_HALF : (w_two ? C_BIT1 : C_RESTART);
            end
        end
    end

    // timeout: the filler pulses push ones until the frame is full
    always_comb begin
        w_fill_end   = {1'b0, r_pulse_cnt} + {4'b0, FRAME_BITS - r_bit_count};
        w_fill       = !r_done && r_last_bit && w_one_zero &&
                       (w_fill_end <= {1'b0, MAX_PULSES});
        w_fill_shift = {r_frame, 14'h3FFF} >> r_bit_count;
        w_fill_frame = w_fill_shift[13:0];
    end

    // next state and result
    always_comb begin
        n_frame     = r_frame;
        n_bit_count = r_bit_count;
        n_last_bit  = r_last_bit;
        n_done      = r_done;
        n_pulse_cnt = r_pulse_cnt;
        n_gate_ok   = r_gate_ok;
        n_pend_vld  = r_pend_vld;
        n_pend_cmd  = r_pend_cmd;
        n_avail     = r_avail;
        n_held_cmd  = r_held_cmd;
        n_out_data  = r_out_data;
        w_frame     = r_frame;
        w_count     = r_bit_count;
        w_last      = r_last_bit;
        w_done      = r_done;

        if (r_in_func == FUNC_PULSE) begin
            if (r_pulse_cnt < MAX_PULSES) begin
                if (r_pulse_cnt == GATE_PULSE) begin
                    n_gate_ok = (r_in_dur > r_gate_thr);
                end
                n_pulse_cnt = r_pulse_cnt + 7'd1;
                if (!r_done) begin
                    // apply the code
                    case (w_code)
                        C_BIT0, C_BIT1: begin
                            w_frame = {r_frame[12:0], (w_code == C_BIT1)};
                            w_count = r_bit_count + 4'd1;
                            w_last  = (w_code == C_BIT1);
                        end
                        C_INVALID: begin
                            w_frame = '0;
                            w_count = '0;
                            w_last  = 1'b0;
                            w_done  = 1'b1;
                        end
                        C_RESTART: begin
                            if (!r_in_rising) begin
                                w_frame = 14'd1;
                                w_count = 4'd1;
                                w_last  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // close a full frame
                    if (w_count >= FRAME_BITS) begin
                        if (w_frame[10:6] == r_wanted_addr) begin
                            n_pend_vld = 1'b1;
                            n_pend_cmd = w_frame[5:0];
                        end
                        w_frame = '0;
                        w_count = '0;
                        w_last  = 1'b0;
                        w_done  = 1'b1;
                    end
                    n_frame     = w_frame;
                    n_bit_count = w_count;
                    n_last_bit  = w_last;
                    n_done      = w_done;
                end
            end
        end else begin
            // judge the burst
            if (r_gate_ok) begin
                if (w_fill && (w_fill_frame[10:6] == r_wanted_addr)) begin
                    n_avail    = 1'b1;
                    n_held_cmd = w_fill_frame[5:0];
                end else if (r_pend_vld) begin
                    n_avail    = 1'b1;
                    n_held_cmd = r_pend_cmd;
                end
            end
            // clear the burst
            n_frame     = '0;
            n_bit_count = '0;
            n_last_bit  = 1'b0;
            n_done      = 1'b0;
            n_pulse_cnt = '0;
            n_gate_ok   = 1'b0;
            n_pend_vld  = 1'b0;
            n_pend_cmd  = '0;
            n_out_data  = {6'd0, cmd_exit(n_held_cmd), cmd_direction(n_held_cmd),
                           n_held_cmd, n_avail};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= RST_BIT_PERIOD;
            r_tolerance   <= RST_TOLERANCE;
            r_wanted_addr <= RST_WANTED_ADDRESS;
            r_gate_thr    <= RST_GATE_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BIT_PERIOD:     r_bit_period  <= i_cfg_wdata;
                CFG_TOLERANCE:      r_tolerance   <= i_cfg_wdata[14:0];
                CFG_WANTED_ADDRESS: r_wanted_addr <= i_cfg_wdata[4:0];
                CFG_GATE_THRESHOLD: r_gate_thr    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_func   <= i_s_axis_tuser;
            r_in_rising <= i_s_axis_tdata[0];
            r_in_dur    <= i_s_axis_tdata[16:1];
        end
    end

    // burst state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_bit_count <= '0;
            r_last_bit  <= 1'b0;
            r_done      <= 1'b0;
            r_pulse_cnt <= '0;
            r_gate_ok   <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_pend_cmd  <= '0;
            r_avail     <= 1'b0;
            r_held_cmd  <= '0;
        end else if (w_fire) begin
            r_frame     <= n_frame;
            r_bit_count <= n_bit_count;
            r_last_bit  <= n_last_bit;
            r_done      <= n_done;
            r_pulse_cnt <= n_pulse_cnt;
            r_gate_ok   <= n_gate_ok;
            r_pend_vld  <= n_pend_vld;
            r_pend_cmd  <= n_pend_cmd;
            r_avail     <= n_avail;
            r_held_cmd  <= n_held_cmd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && (r_in_func == FUNC_TIMEOUT)) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (r_in_func == FUNC_TIMEOUT)) begin
            r_out_data <= n_out_data;
        end
    end

    // checks
    `ASSERT_CLK(a_out_from_timeout, i_clk, i_rst_n,
        $rose(r_out_vld) |-> $past(w_fire && (r_in_func == FUNC_TIMEOUT)),
        "result raised without a timeout")
    `ASSERT_CLK(a_timeout_clears_burst, i_clk, i_rst_n,
        (w_fire && (r_in_func == FUNC_TIMEOUT)) |=> (r_pulse_cnt == 7'd0 && !r_pend_vld),
        "burst state not cleared after timeout")
    `ASSERT_CLK(a_avail_sticky, i_clk, i_rst_n,
        r_avail |=> r_avail,
        "available flag dropped")
    `ASSERT_NEVER(a_frame_open_when_done, i_clk, i_rst_n,
        r_done && (r_bit_count != 4'd0),
        "frame bits left after burst closed")
    `ASSERT_NEVER(a_timeout_overrun, i_clk, i_rst_n,
        w_fire && (r_in_func == FUNC_TIMEOUT) && r_out_vld && !i_m_axis_tready,
        "result overwritten while stalled")

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import rc5_ird_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        func;
        logic        rising;
        logic [15:0] duration;
    } t_ir_item;

    typedef struct packed {
        logic       available;
        logic [5:0] command;
        logic       dir_right;
        logic [1:0] exit_code;
    } t_ir_report;

    typedef enum logic [2:0] {
        PULSE_BIT0,
        PULSE_BIT1,
        PULSE_HALF,
        PULSE_INVALID,
        PULSE_RESTART
    } t_pulse_class;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CFG_BIT_PERIOD;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic        s_user = FUNC_PULSE;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;

    // Register copies used by the decoder prediction
    int unsigned cfg_period = RST_BIT_PERIOD;
    int unsigned cfg_tol    = RST_TOLERANCE;
    int unsigned cfg_addr_w = RST_WANTED_ADDRESS;
    int unsigned cfg_gate   = RST_GATE_THRESHOLD;

    // Predicted decoder state
    logic [13:0] frame_bits = '0;
    int unsigned bit_count = 0;
    logic        last_bit = 1'b0;
    logic        burst_done = 1'b0;
    int unsigned pulse_count = 0;
    logic        gate_ok = 1'b0;
    logic        pending_valid = 1'b0;
    logic [5:0]  pending_cmd = '0;
    logic        avail_flag = 1'b0;
    logic [5:0]  held_cmd = '0;

    t_ir_item    pending_items[$];
    t_ir_report  expected_reports[$];
    t_ir_item    cur_item;
    bit          feeder_busy = 1'b0;
    int          feed_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          long_hold_req = 1'b0;
    bit          idle_on = 1'b1;
    int          items_queued = 0;
    int          mismatches = 0;
    int unsigned cycles = 0;

    rc5_ir_frame_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------
    function automatic bit in_window(input int unsigned d, input int unsigned centre);
        int unsigned lo;
        lo = (centre > cfg_tol) ? centre - cfg_tol : 0;
        return (d >= lo) && (d <= centre + cfg_tol);
    endfunction

    task automatic clear_burst();
        frame_bits = '0;
        bit_count = 0;
        last_bit = 1'b0;
        burst_done = 1'b0;
        pulse_count = 0;
        gate_ok = 1'b0;
        pending_valid = 1'b0;
        pending_cmd = '0;
    endtask

    task automatic decode_pulse(input logic rising, input int unsigned d);
        bit           one_half;
        bit           two_half;
        t_pulse_class cls;
        if (burst_done) return;
        one_half = in_window(d, cfg_period);
        two_half = in_window(d, 2 * cfg_period);
        if (rising) begin
            if (last_bit) cls = one_half ? PULSE_HALF : (two_half ? PULSE_BIT0 : PULSE_RESTART);
            else cls = one_half ? PULSE_BIT0 : (two_half ? PULSE_INVALID : PULSE_RESTART);
        end else begin
            if (last_bit) cls = one_half ? PULSE_BIT1 : (two_half ? PULSE_INVALID : PULSE_RESTART);
            else cls = one_half ? PULSE_HALF : (two_half ? PULSE_BIT1 : PULSE_RESTART);
        end
        case (cls)
            PULSE_BIT0, PULSE_BIT1: begin
                last_bit = (cls == PULSE_BIT1);
                frame_bits = {frame_bits[12:0], last_bit};
                bit_count++;
            end
            PULSE_INVALID: begin
                frame_bits = '0;
                bit_count = 0;
                last_bit = 1'b0;
                burst_done = 1'b1;
            end
            PULSE_RESTART: begin
                // a falling pulse restarts the frame with its start bit
                if (!rising) begin
                    frame_bits = 14'd1;
                    bit_count = 1;
                    last_bit = 1'b1;
                end
            end
            default: ;
        endcase
        // Take address and command once the frame is complete
        if (bit_count >= FRAME_BITS) begin
            if (frame_bits[10:6] == 5'(cfg_addr_w)) begin
                pending_valid = 1'b1;
                pending_cmd = frame_bits[5:0];
            end
            frame_bits = '0;
            bit_count = 0;
            last_bit = 1'b0;
            burst_done = 1'b1;
        end
    endtask

    task automatic decode_transaction(input t_ir_item it);
        t_ir_report rep;
        if (it.func == FUNC_PULSE) begin
            if (pulse_count < MAX_PULSES_N) begin
                if (pulse_count == GATE_PULSE) gate_ok = (it.duration > cfg_gate);
                pulse_count++;
                decode_pulse(it.rising, it.duration);
            end
        end else begin
            // Pad a short burst with zero-length falling pulses, then judge it
            while (pulse_count < MAX_PULSES_N && !burst_done) begin
                pulse_count++;
                decode_pulse(1'b0, 0);
            end
            if (gate_ok && pending_valid) begin
                avail_flag = 1'b1;
                held_cmd = pending_cmd;
            end
            clear_burst();
            rep.available = avail_flag;
            rep.command = held_cmd;
            rep.dir_right = (held_cmd == CMD_R1) || (held_cmd == CMD_R2) ||
                            (held_cmd == CMD_R3);
            case (held_cmd)
                CMD_R1, CMD_L1: rep.exit_code = EXIT_FIRST;
                CMD_R2, CMD_L2: rep.exit_code = EXIT_SECOND;
                default:        rep.exit_code = EXIT_OTHER;
            endcase
            expected_reports.push_back(rep);
        end
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_report(input logic [15:0] word);
        t_ir_report want;
        if (expected_reports.size() == 0) begin
            log_mismatch($sformatf("report with none expected, tdata=%h", word));
            return;
        end
        want = expected_reports.pop_front();
        if (word[0] !== want.available || word[6:1] !== want.command ||
            word[7] !== want.dir_right || word[9:8] !== want.exit_code) begin
            log_mismatch($sformatf(
                "expected avail=%0d cmd=%0d right=%0d exit=%0d, got %0d %0d %0d %0d",
                want.available, want.command, want.dir_right, want.exit_code,
                word[0], word[6:1], word[7], word[9:8]));
        end
    endtask

    // ---------------------------------------------------------------
    // Input driver: present queued items, predict on each transaction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : feeder
        t_ir_item nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data <= '0;
            s_user <= FUNC_PULSE;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                decode_transaction(cur_item);
                feeder_busy = 1'b0;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (idle_on && feed_gap > 0) begin
                    feed_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    cur_item = nxt;
                    feeder_busy = 1'b1;
                    s_valid <= 1'b1;
                    s_data <= {7'b0, nxt.duration, nxt.rising};
                    s_user <= nxt.func;
                    if (idle_on && $urandom_range(0, 7) == 0) feed_gap = $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor with random and long back-pressure
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) check_report(o_m_axis_tdata);
            if (long_hold_req) begin
                hold_left = 400;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idle_on && stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("rc5_ir_frame_decoder_top verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic t_ir_item make_item(input logic func, input logic rising,
                                           input logic [15:0] duration);
        t_ir_item it;
        it.func = func;
        it.rising = rising;
        it.duration = duration;
        return it;
    endfunction

    task automatic queue_item(input t_ir_item it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Duration inside the window around centre, as far as 16 bits allow
    function automatic logic [15:0] near_duration(input int unsigned centre);
        int unsigned lo;
        int unsigned hi;
        lo = (centre > cfg_tol) ? centre - cfg_tol : 0;
        hi = centre + cfg_tol;
        if (hi > 65535) hi = 65535;
        if (lo > hi) return 16'hFFFF;
        return 16'($urandom_range(lo, hi));
    endfunction

    // Duration outside both windows where one exists
    function automatic logic [15:0] restart_duration();
        int unsigned above;
        above = 2 * cfg_period + cfg_tol + 1;
        if (above <= 65535) return 16'($urandom_range(above, 65535));
        if (cfg_period > cfg_tol) return 16'($urandom_range(0, cfg_period - cfg_tol - 1));
        return 16'($urandom);
    endfunction

    function automatic t_ir_item noise_pulse();
        int          pick;
        logic [15:0] d;
        pick = $urandom_range(0, 9);
        if (pick < 4) d = near_duration(cfg_period);
        else if (pick < 7) d = near_duration(2 * cfg_period);
        else d = 16'($urandom);
        return make_item(FUNC_PULSE, 1'($urandom), d);
    endfunction

    function automatic t_ir_item timeout_item();
        return make_item(FUNC_TIMEOUT, 1'($urandom), 16'($urandom));
    endfunction

    // Manchester-coded frame, optionally broken, closed by a timeout
    task automatic gen_frame(input logic [4:0] addr, input logic [5:0] cmd, input bit broken);
        t_ir_item    seq[$];
        logic [13:0] bits;
        logic        prev;
        int          k;
        int          spot;
        bits = {1'b1, 2'($urandom_range(0, 3)), addr, cmd};
        repeat ($urandom_range(0, 1)) seq.push_back(noise_pulse());
        seq.push_back(make_item(FUNC_PULSE, 1'b0, restart_duration()));
        prev = 1'b1;
        for (k = 12; k >= 0; k--) begin
            if (prev) begin
                if (bits[k]) begin
                    seq.push_back(make_item(FUNC_PULSE, 1'b1, near_duration(cfg_period)));
                    seq.push_back(make_item(FUNC_PULSE, 1'b0, near_duration(cfg_period)));
                end else begin
                    seq.push_back(make_item(FUNC_PULSE, 1'b1, near_duration(2 * cfg_period)));
                end
            end else begin
                if (bits[k]) begin
                    seq.push_back(make_item(FUNC_PULSE, 1'b0, near_duration(2 * cfg_period)));
                end else begin
                    seq.push_back(make_item(FUNC_PULSE, 1'b0, near_duration(cfg_period)));
                    seq.push_back(make_item(FUNC_PULSE, 1'b1, near_duration(cfg_period)));
                end
            end
            prev = bits[k];
        end
        // Corrupt one pulse or cut the frame short
        if (broken) begin
            spot = $urandom_range(1, seq.size() - 1);
            if ($urandom_range(0, 1) == 0) seq[spot] = noise_pulse();
            else while (seq.size() > spot) void'(seq.pop_back());
        end
        repeat ($urandom_range(0, 3)) seq.push_back(noise_pulse());
        foreach (seq[i]) queue_item(seq[i]);
        queue_item(timeout_item());
    endtask

    task automatic noise_burst(input int n);
        repeat (n) queue_item(noise_pulse());
        queue_item(timeout_item());
    endtask

    task automatic fill_bursts(input int n);
        int         start;
        int         pick;
        logic [4:0] addr;
        logic [5:0] cmd;
        start = items_queued;
        while (items_queued - start < n) begin
            pick = $urandom_range(0, 99);
            addr = ($urandom_range(0, 9) < 7) ? 5'(cfg_addr_w) : 5'($urandom);
            cmd = ($urandom_range(0, 1) == 1) ? 6'($urandom_range(1, 5)) : 6'($urandom);
            if (pick < 62) gen_frame(addr, cmd, 1'b0);
            else if (pick < 74) gen_frame(addr, cmd, 1'b1);
            else if (pick < 86) noise_burst($urandom_range(0, 14));
            else if (pick < 90) noise_burst($urandom_range(98, 108));
            else noise_burst($urandom_range(0, 3));
        end
    endtask

    // Wait until every item is taken and every report is back, then let
    // the last pulse settle in the block
    task automatic wait_drained();
        while (pending_items.size() != 0 || feeder_busy || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_settings(input int unsigned period, input int unsigned tol,
                                  input int unsigned addr, input int unsigned gate);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_BIT_PERIOD;
        cfg_wdata <= 16'(period);
        @(posedge i_clk);
        cfg_addr <= CFG_TOLERANCE;
        cfg_wdata <= 16'(tol);
        @(posedge i_clk);
        cfg_addr <= CFG_WANTED_ADDRESS;
        cfg_wdata <= 16'(addr);
        @(posedge i_clk);
        cfg_addr <= CFG_GATE_THRESHOLD;
        cfg_wdata <= 16'(gate);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_period = period;
        cfg_tol = tol;
        cfg_addr_w = addr;
        cfg_gate = gate;
    endtask

    task automatic random_settings();
        int unsigned period;
        period = $urandom_range(200, 5000);
        write_settings(period, $urandom_range(0, period / 3), $urandom_range(0, 31),
                       $urandom_range(0, 2 * period));
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty burst, field extremes, invalid mark, one good frame
        queue_item(make_item(FUNC_TIMEOUT, 1'b1, 16'hFFFF));
        queue_item(make_item(FUNC_PULSE, 1'b1, 16'hFFFF));
        queue_item(make_item(FUNC_PULSE, 1'b0, 16'h0000));
        queue_item(make_item(FUNC_TIMEOUT, 1'b0, 16'h0000));
        queue_item(make_item(FUNC_PULSE, 1'b0, 16'd5000));
        queue_item(make_item(FUNC_PULSE, 1'b1, 16'd1800));
        queue_item(make_item(FUNC_PULSE, 1'b1, 16'd1800));
        queue_item(timeout_item());
        gen_frame(5'(RST_WANTED_ADDRESS), CMD_R1, 1'b0);
        wait_drained();

        // Random bursts at reset settings
        fill_bursts(200);
        wait_drained();

        // Narrowest windows, open gate
        write_settings(1, 0, 0, 0);
        fill_bursts(130);
        wait_drained();

        // Widest windows, gate that can never open
        write_settings(65535, 32767, 31, 65535);
        fill_bursts(70);
        wait_drained();

        // Tolerance above the period: zero-length padding decodes as ones
        write_settings(100, 200, 31, 0);
        fill_bursts(90);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        write_settings(RST_BIT_PERIOD, RST_TOLERANCE, RST_WANTED_ADDRESS,
                       RST_GATE_THRESHOLD);
        long_hold_req = 1'b1;
        fill_bursts(180);
        wait_drained();

        repeat (3) begin
            random_settings();
            fill_bursts(130);
            wait_drained();
        end

        // Closing stretch at full rate on both sides
        idle_on = 1'b0;
        random_settings();
        fill_bursts(130);
        wait_drained();

        if (mismatches == 0) begin
            $display("rc5_ir_frame_decoder_top verification clean");
        end else begin
            $display("rc5_ir_frame_decoder_top verification failed");
        end
        $finish;
    end

endmodule
